// ----- sv/lrt_pkg.sv -----
// ============================================================================
// lrt_pkg
// Shared types, codes and helpers for the longest-prefix-match route table.
// ============================================================================
package lrt_pkg;

  // Default table size.
  localparam int ROUTE_ENTRIES = 64;

  // Field widths fixed by the request and result formats.
  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;
  localparam int IF_W   = 8;
  localparam int MODE_W = 2;
  localparam int STAT_W = 3;

  // Longest legal prefix length; longer requests saturate to it.
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

  // Operation codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_MISS     = 3'd1,
    ST_SAME     = 3'd2,
    ST_REPLACED = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_t;

  // One route as it is stored in a cell and reported on a lookup.
  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic              direct;
    logic [ADDR_W-1:0] gateway;
    logic [IF_W-1:0]   ifc;
  } route_t;

  // Search key broadcast to every cell for the request in progress.
  // For a lookup addr is the raw address, otherwise the masked prefix.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              direct;
    logic [ADDR_W-1:0] gateway;
    logic [IF_W-1:0]   ifc;
  } key_t;

  // Partial scan result handed from one cell to the next.
  typedef struct packed {
    logic   hit;
    route_t best;
    logic   exact_found;
    logic   exact_same;
    logic   free_found;
  } scan_t;

  // Write-back command broadcast to the cells; the slot index travels apart.
  typedef struct packed {
    logic   wr_en;
    logic   inv_en;
    logic   clr_all;
    route_t data;
  } wb_t;

  // Network mask with the top len bits set.
  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len >= MAX_LEN) begin
      m = {ADDR_W{1'b1}};
    end else begin
      m = ~({ADDR_W{1'b1}} >> len);
    end
    return m;
  endfunction

endpackage

// ----- sv/lrt_if.sv -----
// ============================================================================
// lrt_if
// Valid/ready channels for route table requests and results.
// ============================================================================

// Request channel: one table operation per transfer.
interface lrt_req_if;
  logic                        valid;
  logic                        ready;
  logic [lrt_pkg::MODE_W-1:0]  mode;
  logic [lrt_pkg::ADDR_W-1:0]  ip_addr;
  logic [lrt_pkg::LEN_W-1:0]   prefix_len;
  logic                        has_next_hop;
  logic [lrt_pkg::ADDR_W-1:0]  gateway_ip;
  logic [lrt_pkg::IF_W-1:0]    out_if;

  modport source (output valid, mode, ip_addr, prefix_len, has_next_hop, gateway_ip,
                  out_if, input ready);
  modport sink   (input valid, mode, ip_addr, prefix_len, has_next_hop, gateway_ip,
                  out_if, output ready);
endinterface

// Result channel: one status and matched route per request.
interface lrt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lrt_pkg::STAT_W-1:0]  status;
  logic [lrt_pkg::ADDR_W-1:0]  route_prefix;
  logic [lrt_pkg::LEN_W-1:0]   route_len;
  logic                        route_direct;
  logic [lrt_pkg::ADDR_W-1:0]  route_gateway;
  logic [lrt_pkg::IF_W-1:0]    route_if;

  modport source (output valid, status, route_prefix, route_len, route_direct,
                  route_gateway, route_if, input ready);
  modport sink   (input valid, status, route_prefix, route_len, route_direct,
                  route_gateway, route_if, output ready);
endinterface

// ----- sv/lrt_cell.sv -----
// ============================================================================
// lrt_cell
// One route table slot plus one stage of the search chain.
// ============================================================================
module lrt_cell #(
  parameter int IW = 6,
  parameter int ID = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lrt_pkg::key_t       key_i,
  input  lrt_pkg::wb_t        wb_i,
  input  logic [IW-1:0]       wb_idx_i,
  input  logic                tok_i,
  input  lrt_pkg::scan_t      carry_i,
  input  logic [IW-1:0]       exact_idx_i,
  input  logic [IW-1:0]       free_idx_i,
  output logic                tok_o,
  output lrt_pkg::scan_t      carry_o,
  output logic [IW-1:0]       exact_idx_o,
  output logic [IW-1:0]       free_idx_o,
  output logic                valid_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(ID);

  logic                valid_r;
  lrt_pkg::route_t     ent_r;
  logic                tok_r;
  lrt_pkg::scan_t      carry_r;
  lrt_pkg::scan_t      carry_nxt;
  logic [IW-1:0]       exact_idx_r;
  logic [IW-1:0]       exact_idx_nxt;
  logic [IW-1:0]       free_idx_r;
  logic [IW-1:0]       free_idx_nxt;
  logic                covers;
  logic                take;
  logic                is_exact;
  logic                sel;

  assign sel = (wb_idx_i == MY_IDX);

  // Valid bit: cleared at reset and by a clear, set or dropped by write-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wb_i.clr_all) begin
      valid_r <= 1'b0;
    end else if (wb_i.inv_en && sel) begin
      valid_r <= 1'b0;
    end else if (wb_i.wr_en && sel) begin
      valid_r <= 1'b1;
    end
  end

  // Route contents are written only together with setting the valid bit.
  always_ff @(posedge clk) begin
    if (wb_i.wr_en && sel) begin
      ent_r <= wb_i.data;
    end
  end

  // Compare this slot against the key and fold it into the running result.
  always_comb begin
    covers   = valid_r &&
               ((key_i.addr & lrt_pkg::len_mask(ent_r.len)) == ent_r.prefix);
    take     = covers && (!carry_i.hit || (ent_r.len > carry_i.best.len));
    is_exact = valid_r && (ent_r.prefix == key_i.addr) && (ent_r.len == key_i.len);

    carry_nxt     = carry_i;
    exact_idx_nxt = exact_idx_i;
    free_idx_nxt  = free_idx_i;

    // Longest covering route wins; ties keep the earlier slot.
    if (take) begin
      carry_nxt.hit  = 1'b1;
      carry_nxt.best = ent_r;
    end

    // First slot holding the same prefix and length.
    if (is_exact && !carry_i.exact_found) begin
      carry_nxt.exact_found = 1'b1;
      carry_nxt.exact_same  = (ent_r.direct == key_i.direct) &&
                              (ent_r.gateway == key_i.gateway) &&
                              (ent_r.ifc == key_i.ifc);
      exact_idx_nxt         = MY_IDX;
    end

    // Lowest free slot.
    if (!valid_r && !carry_i.free_found) begin
      carry_nxt.free_found = 1'b1;
      free_idx_nxt         = MY_IDX;
    end
  end

  // Token marks the stage that holds the live request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_i;
    end
  end

  // Hand the partial result to the next cell.
  always_ff @(posedge clk) begin
    carry_r     <= carry_nxt;
    exact_idx_r <= exact_idx_nxt;
    free_idx_r  <= free_idx_nxt;
  end

  assign tok_o       = tok_r;
  assign carry_o     = carry_r;
  assign exact_idx_o = exact_idx_r;
  assign free_idx_o  = free_idx_r;
  assign valid_o     = valid_r;

endmodule

// ----- sv/lpm_route_table_unit.sv -----
// ============================================================================
// lpm_route_table_unit
// IPv4 route table with longest-prefix-match lookup, add, delete and clear.
// ============================================================================
//
//   channel  | dir | handshake       | carries
//   ---------+-----+-----------------+----------------------------------------
//   in_ch    | in  | valid / ready   | mode, ip_addr, prefix_len, next hop
//   out_ch   | out | valid / ready   | status and matched route
//
// For each request a token walks the chain of slot cells, one cell per cycle;
// the final scan result is then captured, the done state writes back and
// loads the output register once that register is free, and the idle state
// takes the next request.
// Reset clears every valid bit at once; the table is usable right away.
// A finished result waits in the output register while the next request is
// taken; write-back of that next request waits until the register is free.
//
module lpm_route_table_unit #(
  parameter int ROUTE_ENTRIES = lrt_pkg::ROUTE_ENTRIES
) (
  input logic        clk,
  input logic        rst_n,
  lrt_req_if.sink    in_ch,
  lrt_rsp_if.source  out_ch
);

  localparam int IW = $clog2(ROUTE_ENTRIES);

  lrt_pkg::state_t              state_r;
  lrt_pkg::state_t              state_nxt;
  lrt_pkg::mode_t               mode_r;
  lrt_pkg::key_t                key_r;
  logic                         launch_r;
  lrt_pkg::scan_t               fin_r;
  logic [IW-1:0]                fin_exact_idx_r;
  logic [IW-1:0]                fin_free_idx_r;
  logic                         out_valid_r;
  lrt_pkg::status_t             out_status_r;
  lrt_pkg::status_t             status_nxt;
  lrt_pkg::route_t              out_route_r;
  lrt_pkg::route_t              route_nxt;
  lrt_pkg::wb_t                 wb;
  logic [IW-1:0]                wb_idx;
  logic                         in_acc;
  logic                         out_free;
  logic                         done_fire;
  logic [lrt_pkg::LEN_W-1:0]    len_sat;

  lrt_pkg::scan_t               chain [0:ROUTE_ENTRIES];
  logic [IW-1:0]                ex_idx [0:ROUTE_ENTRIES];
  logic [IW-1:0]                fr_idx [0:ROUTE_ENTRIES];
  logic [ROUTE_ENTRIES:0]       tok_v;
  logic [ROUTE_ENTRIES-1:0]     valid_v;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign done_fire = (state_r == lrt_pkg::S_DONE) && out_free;
  assign in_ch.ready = (state_r == lrt_pkg::S_IDLE);

  // Controller state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: accept, walk the chain, then write back.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrt_pkg::S_IDLE: begin
        if (in_acc) state_nxt = lrt_pkg::S_SCAN;
      end
      lrt_pkg::S_SCAN: begin
        if (tok_v[ROUTE_ENTRIES]) state_nxt = lrt_pkg::S_DONE;
      end
      lrt_pkg::S_DONE: begin
        if (out_free) state_nxt = lrt_pkg::S_IDLE;
      end
      default: state_nxt = lrt_pkg::S_IDLE;
    endcase
  end

  // Launch pulse starts the token at the head of the chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r <= 1'b0;
    end else begin
      launch_r <= in_acc;
    end
  end

  // Build the search key; add and delete use the masked, saturated prefix.
  assign len_sat = (in_ch.prefix_len > lrt_pkg::MAX_LEN) ? lrt_pkg::MAX_LEN
                                                          : in_ch.prefix_len;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r        <= lrt_pkg::mode_t'(in_ch.mode);
      key_r.len     <= len_sat;
      key_r.direct  <= !in_ch.has_next_hop;
      key_r.gateway <= in_ch.has_next_hop ? in_ch.gateway_ip : '0;
      key_r.ifc     <= in_ch.has_next_hop ? in_ch.out_if : '0;
      if (lrt_pkg::mode_t'(in_ch.mode) == lrt_pkg::MODE_LOOKUP) begin
        key_r.addr <= in_ch.ip_addr;
      end else begin
        key_r.addr <= in_ch.ip_addr & lrt_pkg::len_mask(len_sat);
      end
    end
  end

  // Head of the chain: nothing found yet.
  assign chain[0]  = '0;
  assign ex_idx[0] = '0;
  assign fr_idx[0] = '0;
  assign tok_v[0]  = launch_r;

  // Row of slot cells.
  for (genvar g = 0; g < ROUTE_ENTRIES; g++) begin : g_cell
    lrt_cell #(
      .IW (IW),
      .ID (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .key_i       (key_r),
      .wb_i        (wb),
      .wb_idx_i    (wb_idx),
      .tok_i       (tok_v[g]),
      .carry_i     (chain[g]),
      .exact_idx_i (ex_idx[g]),
      .free_idx_i  (fr_idx[g]),
      .tok_o       (tok_v[g+1]),
      .carry_o     (chain[g+1]),
      .exact_idx_o (ex_idx[g+1]),
      .free_idx_o  (fr_idx[g+1]),
      .valid_o     (valid_v[g])
    );
  end

  // Capture the final scan result when the token leaves the last cell.
  always_ff @(posedge clk) begin
    if ((state_r == lrt_pkg::S_SCAN) && tok_v[ROUTE_ENTRIES]) begin
      fin_r           <= chain[ROUTE_ENTRIES];
      fin_exact_idx_r <= ex_idx[ROUTE_ENTRIES];
      fin_free_idx_r  <= fr_idx[ROUTE_ENTRIES];
    end
  end

  // Decide status, result route and write-back from the scan result.
  always_comb begin
    wb.wr_en   = 1'b0;
    wb.inv_en  = 1'b0;
    wb.clr_all = 1'b0;
    wb.data.prefix  = key_r.addr;
    wb.data.len     = key_r.len;
    wb.data.direct  = key_r.direct;
    wb.data.gateway = key_r.gateway;
    wb.data.ifc     = key_r.ifc;
    wb_idx     = fin_exact_idx_r;
    status_nxt = lrt_pkg::ST_OK;
    route_nxt  = '0;
    unique case (mode_r)
      lrt_pkg::MODE_LOOKUP: begin
        if (fin_r.hit) begin
          route_nxt = fin_r.best;
        end else begin
          status_nxt = lrt_pkg::ST_MISS;
        end
      end
      lrt_pkg::MODE_ADD: begin
        if (fin_r.exact_found) begin
          if (fin_r.exact_same) begin
            status_nxt = lrt_pkg::ST_SAME;
          end else begin
            status_nxt = lrt_pkg::ST_REPLACED;
            wb.wr_en   = done_fire;
          end
        end else if (fin_r.free_found) begin
          wb_idx   = fin_free_idx_r;
          wb.wr_en = done_fire;
        end else begin
          status_nxt = lrt_pkg::ST_FULL;
        end
      end
      lrt_pkg::MODE_DELETE: begin
        if (fin_r.exact_found) begin
          wb.inv_en = done_fire;
        end else begin
          status_nxt = lrt_pkg::ST_MISS;
        end
      end
      lrt_pkg::MODE_CLEAR: begin
        wb.clr_all = done_fire;
      end
      default: status_nxt = lrt_pkg::ST_OK;
    endcase
  end

  // Output register; it frees the chain while the result waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_status_r <= status_nxt;
      out_route_r  <= route_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.route_prefix  = out_route_r.prefix;
  assign out_ch.route_len     = out_route_r.len;
  assign out_ch.route_direct  = out_route_r.direct;
  assign out_ch.route_gateway = out_route_r.gateway;
  assign out_ch.route_if      = out_route_r.ifc;

  // At most one request is in flight along the chain.
  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_v))
    else $error("more than one token in the search chain");

  // An accepted request starts its walk in the next cycle.
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ((state_r == lrt_pkg::S_SCAN) && launch_r))
    else $error("accepted request did not launch a scan");

  // A result appears only after a write-back cycle.
  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r == lrt_pkg::S_DONE))
    else $error("result produced without a completed scan");

  // A clear leaves every slot invalid.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (done_fire && (mode_r == lrt_pkg::MODE_CLEAR)) |=> (valid_v == '0))
    else $error("clear left a valid slot");

endmodule
